// ===== design/circle_through_three_points_macros.svh =====
// ----------------------------------------------------------------------------
// Circle through three points: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_THROUGH_THREE_POINTS_MACROS_SVH
`define CIRCLE_THROUGH_THREE_POINTS_MACROS_SVH

// Same-cycle implication.
`define CTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ctp_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle through three points: package
// Word types of the input and result channels and the default fraction width.
// ----------------------------------------------------------------------------
`default_nettype none

package ctp_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRACTION_BITS_DEF = 16;

  // Input word: three points, signed fixed point.
  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] third_x;
    logic signed [31:0] third_y;
  } ctp_in_t;

  // Result word: general-form coefficients, radius and flags.
  typedef struct packed {
    logic signed [47:0] half_x_coefficient;
    logic signed [47:0] half_y_coefficient;
    logic signed [63:0] constant_term;
    logic        [47:0] radius;
    logic               collinear;
    logic               overflow;
  } ctp_out_t;

endpackage

`default_nettype wire

// ===== design/circle_through_three_points.sv =====
// ----------------------------------------------------------------------------
// Circle through three points: pipelined from start to out_valid.
// Throughput one word per cycle; busy stays low, results are never held off.
// Length is set by the 99-stage quotient pipeline and 49-stage square root.
// Synchronous active-low reset clears all valid bits; data regs are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circle_through_three_points_macros.svh"

module circle_through_three_points #(
  parameter int FRACTION_BITS = ctp_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ctp_pkg::ctp_in_t  in_pts,
  output logic              busy,
  output logic              out_valid,
  output ctp_pkg::ctp_out_t out_res
);

  // Pipeline geometry.
  localparam int QW     = 99;            // quotient and numerator width
  localparam int NDIV   = QW;            // one quotient bit per stage
  localparam int DIV_W  = 66;            // divisor and remainder width
  localparam int GS_W   = 101;           // x1 + QX width
  localparam int CW     = 134;           // constant term accumulator width
  localparam int NSQ    = 49;            // root bits, one per stage
  localparam int RAD_W  = 2 * NSQ;
  localparam int REM_W  = NSQ + 2;
  localparam int LAT    = 7 + NDIV + 6 + NSQ + 2;

  localparam logic [CW-1:0] C_HALF    = CW'(1) << (FRACTION_BITS - 1);
  localparam logic [CW-1:0] C_HALF_M1 = C_HALF - CW'(1);
  localparam logic signed [GS_W-1:0] G_POS = GS_W'(1) << 47;
  localparam logic signed [GS_W-1:0] G_NEG = GS_W'(1) - G_POS;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic [64:0]        k;
    logic               qsx;
    logic               qsy;
    logic               col;
  } div_side_t;

  typedef struct packed {
    logic [47:0] g;
    logic [47:0] f;
    logic [63:0] c;
    logic        ovf;
    logic        big;
    logic        col;
  } sq_side_t;

  // Magnitude of a 33-bit two's complement difference.
  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  function automatic logic [65:0] sgn66(input logic s, input logic [63:0] m);
    return s ? -{2'b00, m} : {2'b00, m};
  endfunction

  function automatic logic [98:0] sgn99(input logic s, input logic [96:0] m);
    return s ? -{2'b00, m} : {2'b00, m};
  endfunction

  function automatic logic [100:0] sgn101(input logic s, input logic [98:0] m);
    return s ? -{2'b00, m} : {2'b00, m};
  endfunction

  function automatic logic [133:0] sgn134(input logic s, input logic [131:0] m);
    return s ? -{2'b00, m} : {2'b00, m};
  endfunction

  // Negate a sum and saturate it to 48 bits; top bit of the result is overflow.
  function automatic logic [48:0] neg_sat48(input logic [GS_W-1:0] s);
    logic signed [GS_W-1:0] ss;
    logic [47:0] n;
    ss = s;
    n  = -s[47:0];
    if (ss > G_POS) begin
      return {1'b1, 48'h8000_0000_0000};
    end else if (ss < G_NEG) begin
      return {1'b1, 48'h7FFF_FFFF_FFFF};
    end else begin
      return {1'b0, n};
    end
  endfunction

  // Stage 1: differences relative to the first point.
  logic [32:0] du2, dv2, du3, dv3;
  logic [31:0] s1_u2m_r, s1_v2m_r, s1_u3m_r, s1_v3m_r;
  logic        s1_u2s_r, s1_v2s_r, s1_u3s_r, s1_v3s_r;
  logic [31:0] s1_x1_r, s1_y1_r;

  // Stage 2: 32x32 products.
  logic [63:0] s2_puv_r, s2_pvu_r, s2_uu2_r, s2_vv2_r, s2_uu3_r, s2_vv3_r;
  logic [63:0] s2_kx_r, s2_ky_r;
  logic        s2_puvs_r, s2_pvus_r;
  logic [31:0] s2_u2m_r, s2_v2m_r, s2_u3m_r, s2_v3m_r;
  logic        s2_u2s_r, s2_v2s_r, s2_u3s_r, s2_v3s_r;
  logic [31:0] s2_x1_r, s2_y1_r;

  // Stage 3: determinant and squared distances.
  logic [65:0] s3_d0_r;
  logic [64:0] s3_sq2_r, s3_sq3_r, s3_k_r;
  logic [31:0] s3_u2m_r, s3_v2m_r, s3_u3m_r, s3_v3m_r;
  logic        s3_u2s_r, s3_v2s_r, s3_u3s_r, s3_v3s_r;
  logic [31:0] s3_x1_r, s3_y1_r;

  // Stage 4: partial products of the Cramer numerators.
  logic [65:0] d0_neg;
  logic [31:0] pm [0:3];
  logic [64:0] ps [0:3];
  logic [3:0]  psg;
  logic [63:0] s4_lo_r [0:3];
  logic [64:0] s4_hi_r [0:3];
  logic [3:0]  s4_sg_r;
  logic [64:0] s4_dm_r, s4_k_r;
  logic        s4_ds_r, s4_col_r;
  logic [31:0] s4_x1_r, s4_y1_r;

  // Stage 5: whole products.
  logic [96:0] s5_m_r [0:3];
  logic [3:0]  s5_sg_r;
  logic [64:0] s5_dm_r, s5_k_r;
  logic        s5_ds_r, s5_col_r;
  logic [31:0] s5_x1_r, s5_y1_r;

  // Stage 6: signed numerators.
  logic [98:0] s6_nx_r, s6_ny_r;
  logic [64:0] s6_dm_r, s6_k_r;
  logic        s6_ds_r, s6_col_r;
  logic [31:0] s6_x1_r, s6_y1_r;

  // Stage 7 and divider: rounded quotient, one bit per stage.
  logic [98:0] nx_neg, ny_neg;
  logic [97:0] nxm, nym;
  logic [QW-1:0]    dax_r [0:NDIV];
  logic [QW-1:0]    day_r [0:NDIV];
  logic [DIV_W-1:0] drx_r [0:NDIV];
  logic [DIV_W-1:0] dry_r [0:NDIV];
  logic [DIV_W-1:0] ddv_r [0:NDIV];
  div_side_t        dsd_r [0:NDIV];
  logic [DIV_W:0]   dx_sh [0:NDIV-1];
  logic [DIV_W:0]   dx_rn [0:NDIV-1];
  logic [DIV_W:0]   dy_sh [0:NDIV-1];
  logic [DIV_W:0]   dy_rn [0:NDIV-1];
  logic             dx_ge [0:NDIV-1];
  logic             dy_ge [0:NDIV-1];

  // Post-divide stages.
  div_side_t   pd;
  logic [QW-1:0] qxm, qym;
  logic [31:0] x1m, y1m;
  logic [GS_W-1:0] p1_gx_r, p1_gy_r;
  logic [63:0] p1_cx0_r, p1_cx1_r, p1_cy0_r, p1_cy1_r;
  logic [66:0] p1_cx2_r, p1_cy2_r;
  logic        p1_csx_r, p1_csy_r;
  logic [47:0] p1_hhx_r, p1_hlx_r, p1_llx_r, p1_hhy_r, p1_hly_r, p1_lly_r;
  logic        p1_big_r, p1_col_r;
  logic [64:0] p1_k_r;

  logic [48:0] gsat, fsat;
  logic [47:0] p2_g_r, p2_f_r;
  logic        p2_ovf_r, p2_csx_r, p2_csy_r, p2_big_r, p2_col_r;
  logic [130:0] p2_mx_r, p2_my_r;
  logic [95:0] p2_xx_r, p2_yy_r;
  logic [64:0] p2_k_r;

  logic [CW-1:0] p3_t_r;
  logic [96:0]   p3_rsq_r;
  logic [47:0]   p3_g_r, p3_f_r;
  logic          p3_ovf_r, p3_big_r, p3_col_r;
  logic [64:0]   p3_k_r;

  logic [CW-1:0] p4_cn_r;
  logic [96:0]   p4_rsq_r;
  logic [47:0]   p4_g_r, p4_f_r;
  logic          p4_ovf_r, p4_big_r, p4_col_r;

  logic signed [CW-1:0] cadj;
  logic [CW-1:0] p5_cr_r;
  logic [96:0]   p5_rsq_r;
  logic [47:0]   p5_g_r, p5_f_r;
  logic          p5_ovf_r, p5_big_r, p5_col_r;

  logic          c_fits;
  logic [63:0]   csat;

  // Square root stages.
  logic [RAD_W-1:0] sqa_r [0:NSQ];
  logic [REM_W-1:0] sqr_r [0:NSQ];
  logic [NSQ-1:0]   sqt_r [0:NSQ];
  sq_side_t         sqs_r [0:NSQ];
  logic [REM_W+1:0] sq_sh [0:NSQ-1];
  logic [REM_W+1:0] sq_tr [0:NSQ-1];
  logic [REM_W+1:0] sq_rn [0:NSQ-1];
  logic             sq_ge [0:NSQ-1];

  // Final rounding and output.
  logic [NSQ:0]        r1_rr_r;
  sq_side_t            r1_sd_r;
  logic                rover;
  ctp_pkg::ctp_out_t   res_nxt;
  ctp_pkg::ctp_out_t   out_res_r;
  logic [LAT-1:0]      vld_r;

  // Front-end combinational terms.
  always_comb begin
    du2 = {in_pts.second_x[31], in_pts.second_x} - {in_pts.first_x[31], in_pts.first_x};
    dv2 = {in_pts.second_y[31], in_pts.second_y} - {in_pts.first_y[31], in_pts.first_y};
    du3 = {in_pts.third_x[31], in_pts.third_x} - {in_pts.first_x[31], in_pts.first_x};
    dv3 = {in_pts.third_y[31], in_pts.third_y} - {in_pts.first_y[31], in_pts.first_y};
    d0_neg = -s3_d0_r;
    pm[0] = s3_v3m_r;  ps[0] = s3_sq2_r;  psg[0] = s3_v3s_r;
    pm[1] = s3_v2m_r;  ps[1] = s3_sq3_r;  psg[1] = ~s3_v2s_r;
    pm[2] = s3_u2m_r;  ps[2] = s3_sq3_r;  psg[2] = s3_u2s_r;
    pm[3] = s3_u3m_r;  ps[3] = s3_sq2_r;  psg[3] = ~s3_u3s_r;
    nx_neg = -s6_nx_r;
    ny_neg = -s6_ny_r;
    nxm = s6_nx_r[98] ? nx_neg[97:0] : s6_nx_r[97:0];
    nym = s6_ny_r[98] ? ny_neg[97:0] : s6_ny_r[97:0];
  end

  // Divider stage logic: restoring step per stage.
  always_comb begin
    for (int i = 0; i < NDIV; i++) begin
      dx_sh[i] = {drx_r[i], dax_r[i][QW-1]};
      dx_ge[i] = dx_sh[i] >= {1'b0, ddv_r[i]};
      dx_rn[i] = dx_ge[i] ? dx_sh[i] - {1'b0, ddv_r[i]} : dx_sh[i];
      dy_sh[i] = {dry_r[i], day_r[i][QW-1]};
      dy_ge[i] = dy_sh[i] >= {1'b0, ddv_r[i]};
      dy_rn[i] = dy_ge[i] ? dy_sh[i] - {1'b0, ddv_r[i]} : dy_sh[i];
    end
  end

  // Post-divide combinational terms.
  always_comb begin
    pd   = dsd_r[NDIV];
    qxm  = dax_r[NDIV];
    qym  = day_r[NDIV];
    x1m  = mag33({pd.x1[31], pd.x1});
    y1m  = mag33({pd.y1[31], pd.y1});
    gsat = neg_sat48(p1_gx_r);
    fsat = neg_sat48(p1_gy_r);
    cadj = p4_cn_r + (p4_cn_r[CW-1] ? C_HALF_M1 : C_HALF);
    c_fits = (&p5_cr_r[CW-1:63]) | ~(|p5_cr_r[CW-1:63]);
    if (c_fits) begin
      csat = p5_cr_r[63:0];
    end else if (p5_cr_r[CW-1]) begin
      csat = 64'h8000_0000_0000_0000;
    end else begin
      csat = 64'h7FFF_FFFF_FFFF_FFFF;
    end
  end

  // Square root stage logic: one root bit per stage.
  always_comb begin
    for (int i = 0; i < NSQ; i++) begin
      sq_sh[i] = {sqr_r[i], sqa_r[i][RAD_W-1 -: 2]};
      sq_tr[i] = {2'b00, sqt_r[i], 2'b01};
      sq_ge[i] = sq_sh[i] >= sq_tr[i];
      sq_rn[i] = sq_ge[i] ? sq_sh[i] - sq_tr[i] : sq_sh[i];
    end
  end

  // Radius saturation and result assembly.
  always_comb begin
    rover   = r1_sd_r.big | (|r1_rr_r[NSQ:48]);
    res_nxt = '0;
    if (r1_sd_r.col) begin
      res_nxt.collinear = 1'b1;
    end else begin
      res_nxt.half_x_coefficient = r1_sd_r.g;
      res_nxt.half_y_coefficient = r1_sd_r.f;
      res_nxt.constant_term      = r1_sd_r.c;
      res_nxt.radius             = rover ? '1 : r1_rr_r[47:0];
      res_nxt.overflow           = r1_sd_r.ovf | rover;
    end
  end

  // Data pipeline registers.
  always_ff @(posedge clk) begin
    // Stage 1.
    s1_u2m_r <= mag33(du2);  s1_u2s_r <= du2[32];
    s1_v2m_r <= mag33(dv2);  s1_v2s_r <= dv2[32];
    s1_u3m_r <= mag33(du3);  s1_u3s_r <= du3[32];
    s1_v3m_r <= mag33(dv3);  s1_v3s_r <= dv3[32];
    s1_x1_r  <= in_pts.first_x;
    s1_y1_r  <= in_pts.first_y;
    // Stage 2.
    s2_puv_r  <= s1_u2m_r * s1_v3m_r;
    s2_pvu_r  <= s1_u3m_r * s1_v2m_r;
    s2_puvs_r <= s1_u2s_r ^ s1_v3s_r;
    s2_pvus_r <= s1_u3s_r ^ s1_v2s_r;
    s2_uu2_r  <= s1_u2m_r * s1_u2m_r;
    s2_vv2_r  <= s1_v2m_r * s1_v2m_r;
    s2_uu3_r  <= s1_u3m_r * s1_u3m_r;
    s2_vv3_r  <= s1_v3m_r * s1_v3m_r;
    s2_kx_r   <= mag33({s1_x1_r[31], s1_x1_r}) * mag33({s1_x1_r[31], s1_x1_r});
    s2_ky_r   <= mag33({s1_y1_r[31], s1_y1_r}) * mag33({s1_y1_r[31], s1_y1_r});
    s2_u2m_r <= s1_u2m_r;  s2_u2s_r <= s1_u2s_r;
    s2_v2m_r <= s1_v2m_r;  s2_v2s_r <= s1_v2s_r;
    s2_u3m_r <= s1_u3m_r;  s2_u3s_r <= s1_u3s_r;
    s2_v3m_r <= s1_v3m_r;  s2_v3s_r <= s1_v3s_r;
    s2_x1_r  <= s1_x1_r;   s2_y1_r  <= s1_y1_r;
    // Stage 3.
    s3_d0_r  <= sgn66(s2_puvs_r, s2_puv_r) - sgn66(s2_pvus_r, s2_pvu_r);
    s3_sq2_r <= {1'b0, s2_uu2_r} + {1'b0, s2_vv2_r};
    s3_sq3_r <= {1'b0, s2_uu3_r} + {1'b0, s2_vv3_r};
    s3_k_r   <= {1'b0, s2_kx_r} + {1'b0, s2_ky_r};
    s3_u2m_r <= s2_u2m_r;  s3_u2s_r <= s2_u2s_r;
    s3_v2m_r <= s2_v2m_r;  s3_v2s_r <= s2_v2s_r;
    s3_u3m_r <= s2_u3m_r;  s3_u3s_r <= s2_u3s_r;
    s3_v3m_r <= s2_v3m_r;  s3_v3s_r <= s2_v3s_r;
    s3_x1_r  <= s2_x1_r;   s3_y1_r  <= s2_y1_r;
    // Stage 4.
    for (int j = 0; j < 4; j++) begin
      s4_lo_r[j] <= pm[j] * ps[j][31:0];
      s4_hi_r[j] <= pm[j] * ps[j][64:32];
    end
    s4_sg_r  <= psg;
    s4_dm_r  <= s3_d0_r[65] ? d0_neg[64:0] : s3_d0_r[64:0];
    s4_ds_r  <= s3_d0_r[65];
    s4_col_r <= (s3_d0_r == '0);
    s4_k_r   <= s3_k_r;
    s4_x1_r  <= s3_x1_r;  s4_y1_r <= s3_y1_r;
    // Stage 5.
    for (int j = 0; j < 4; j++) begin
      s5_m_r[j] <= {33'b0, s4_lo_r[j]} + {s4_hi_r[j], 32'b0};
    end
    s5_sg_r  <= s4_sg_r;
    s5_dm_r  <= s4_dm_r;  s5_ds_r <= s4_ds_r;  s5_col_r <= s4_col_r;
    s5_k_r   <= s4_k_r;
    s5_x1_r  <= s4_x1_r;  s5_y1_r <= s4_y1_r;
    // Stage 6.
    s6_nx_r  <= sgn99(s5_sg_r[0], s5_m_r[0]) + sgn99(s5_sg_r[1], s5_m_r[1]);
    s6_ny_r  <= sgn99(s5_sg_r[2], s5_m_r[2]) + sgn99(s5_sg_r[3], s5_m_r[3]);
    s6_dm_r  <= s5_dm_r;  s6_ds_r <= s5_ds_r;  s6_col_r <= s5_col_r;
    s6_k_r   <= s5_k_r;
    s6_x1_r  <= s5_x1_r;  s6_y1_r <= s5_y1_r;
    // Stage 7: rounded-division operands, ties away from zero.
    dax_r[0] <= {1'b0, nxm} + {34'b0, s6_dm_r};
    day_r[0] <= {1'b0, nym} + {34'b0, s6_dm_r};
    drx_r[0] <= '0;
    dry_r[0] <= '0;
    ddv_r[0] <= {s6_dm_r, 1'b0};
    dsd_r[0] <= '{x1: s6_x1_r, y1: s6_y1_r, k: s6_k_r,
                  qsx: s6_nx_r[98] ^ s6_ds_r, qsy: s6_ny_r[98] ^ s6_ds_r,
                  col: s6_col_r};
    // Divider stages.
    for (int i = 0; i < NDIV; i++) begin
      dax_r[i+1] <= {dax_r[i][QW-2:0], dx_ge[i]};
      day_r[i+1] <= {day_r[i][QW-2:0], dy_ge[i]};
      drx_r[i+1] <= dx_rn[i][DIV_W-1:0];
      dry_r[i+1] <= dy_rn[i][DIV_W-1:0];
      ddv_r[i+1] <= ddv_r[i];
      dsd_r[i+1] <= dsd_r[i];
    end
    // Post-divide stage 1: centre sums, product chunks, square chunks.
    p1_gx_r  <= {{69{pd.x1[31]}}, pd.x1} + sgn101(pd.qsx, qxm);
    p1_gy_r  <= {{69{pd.y1[31]}}, pd.y1} + sgn101(pd.qsy, qym);
    p1_cx0_r <= x1m * qxm[31:0];
    p1_cx1_r <= x1m * qxm[63:32];
    p1_cx2_r <= x1m * qxm[98:64];
    p1_cy0_r <= y1m * qym[31:0];
    p1_cy1_r <= y1m * qym[63:32];
    p1_cy2_r <= y1m * qym[98:64];
    p1_csx_r <= pd.x1[31] ^ pd.qsx;
    p1_csy_r <= pd.y1[31] ^ pd.qsy;
    p1_hhx_r <= qxm[47:24] * qxm[47:24];
    p1_hlx_r <= qxm[47:24] * qxm[23:0];
    p1_llx_r <= qxm[23:0] * qxm[23:0];
    p1_hhy_r <= qym[47:24] * qym[47:24];
    p1_hly_r <= qym[47:24] * qym[23:0];
    p1_lly_r <= qym[23:0] * qym[23:0];
    p1_big_r <= (|qxm[QW-1:48]) | (|qym[QW-1:48]);
    p1_k_r   <= pd.k;
    p1_col_r <= pd.col;
    // Post-divide stage 2.
    p2_g_r   <= gsat[47:0];
    p2_f_r   <= fsat[47:0];
    p2_ovf_r <= gsat[48] | fsat[48];
    p2_mx_r  <= {p1_cx2_r, p1_cx0_r} + {35'b0, p1_cx1_r, 32'b0};
    p2_my_r  <= {p1_cy2_r, p1_cy0_r} + {35'b0, p1_cy1_r, 32'b0};
    p2_csx_r <= p1_csx_r;  p2_csy_r <= p1_csy_r;
    p2_xx_r  <= {p1_hhx_r, p1_llx_r} + {23'b0, p1_hlx_r, 25'b0};
    p2_yy_r  <= {p1_hhy_r, p1_lly_r} + {23'b0, p1_hly_r, 25'b0};
    p2_big_r <= p1_big_r;  p2_k_r <= p1_k_r;  p2_col_r <= p1_col_r;
    // Post-divide stage 3.
    p3_t_r   <= sgn134(p2_csx_r, {p2_mx_r, 1'b0}) + sgn134(p2_csy_r, {p2_my_r, 1'b0});
    p3_rsq_r <= {1'b0, p2_xx_r} + {1'b0, p2_yy_r};
    p3_g_r   <= p2_g_r;    p3_f_r <= p2_f_r;    p3_ovf_r <= p2_ovf_r;
    p3_big_r <= p2_big_r;  p3_k_r <= p2_k_r;    p3_col_r <= p2_col_r;
    // Post-divide stage 4.
    p4_cn_r  <= p3_t_r + {69'b0, p3_k_r};
    p4_rsq_r <= p3_rsq_r;
    p4_g_r   <= p3_g_r;    p4_f_r <= p3_f_r;    p4_ovf_r <= p3_ovf_r;
    p4_big_r <= p3_big_r;  p4_col_r <= p3_col_r;
    // Post-divide stage 5: round the constant term.
    p5_cr_r  <= cadj >>> FRACTION_BITS;
    p5_rsq_r <= p4_rsq_r;
    p5_g_r   <= p4_g_r;    p5_f_r <= p4_f_r;    p5_ovf_r <= p4_ovf_r;
    p5_big_r <= p4_big_r;  p5_col_r <= p4_col_r;
    // Post-divide stage 6: saturate c, load the root pipeline.
    sqa_r[0] <= {1'b0, p5_rsq_r};
    sqr_r[0] <= '0;
    sqt_r[0] <= '0;
    sqs_r[0] <= '{g: p5_g_r, f: p5_f_r, c: csat, ovf: p5_ovf_r | ~c_fits,
                  big: p5_big_r, col: p5_col_r};
    // Root stages.
    for (int i = 0; i < NSQ; i++) begin
      sqa_r[i+1] <= {sqa_r[i][RAD_W-3:0], 2'b00};
      sqr_r[i+1] <= sq_rn[i][REM_W-1:0];
      sqt_r[i+1] <= {sqt_r[i][NSQ-2:0], sq_ge[i]};
      sqs_r[i+1] <= sqs_r[i];
    end
    // Round the root to nearest.
    r1_rr_r <= {1'b0, sqt_r[NSQ]} +
               (NSQ+1)'(sqr_r[NSQ] > {2'b00, sqt_r[NSQ]});
    r1_sd_r <= sqs_r[NSQ];
    // Output register.
    out_res_r <= res_nxt;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  assign busy      = 1'b0;
  assign out_valid = vld_r[LAT-1];
  assign out_res   = out_res_r;

  // Every result word comes from a start exactly one latency earlier.
  `CTP_ASSERT_IMP(a_latency, out_valid, $past(start, LAT), "result without matching start")
  // Collinear words carry all-zero results.
  `CTP_ASSERT_IMP(a_col_zero, out_valid && out_res.collinear, out_res.radius == '0 && out_res.half_x_coefficient == '0 && out_res.half_y_coefficient == '0 && out_res.constant_term == '0 && !out_res.overflow, "collinear word not cleared")
  // A start is always taken, so its valid bit enters the pipeline.
  `CTP_ASSERT_NXT(a_enter, start, vld_r[0], "accepted word lost at entry")

endmodule

`default_nettype wire

// ===== dv/circle_through_three_points_tb.sv =====
// ----------------------------------------------------------------------------
// Circle through three points: testbench
// Sends point triples in bursts and predicts each result with exact wide
// integer arithmetic. Every result word is checked field by field against the
// oldest expected word.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_through_three_points_tb;

  typedef logic signed [255:0] wide_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  ctp_pkg::ctp_in_t  in_pts;
  logic              busy;
  logic              out_valid;
  ctp_pkg::ctp_out_t out_res;

  ctp_pkg::ctp_out_t circle_q[$];
  int                error_count;
  int                burst_left;

  circle_through_three_points dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_pts   (in_pts),
    .busy     (busy),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  // Clock with a period of two time units.
  always #1 clk = ~clk;

  // Division rounded to nearest, ties away from zero.
  function automatic wide_t div_nearest(wide_t num, wide_t den);
    wide_t nm;
    wide_t dm;
    wide_t q;
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    q  = (2 * nm + dm) / (2 * dm);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  // Square root rounded to nearest.
  function automatic wide_t sqrt_nearest(wide_t v);
    wide_t r;
    wide_t t;
    r = 0;
    for (int i = 127; i >= 0; i--) begin
      t = r | (wide_t'(1) << i);
      if (t * t <= v) r = t;
    end
    if (v - r * r > r) r = r + 1;
    return r;
  endfunction

  // Signed saturation to the given width.
  function automatic logic [63:0] clamp_signed(wide_t v, int bits, inout bit ovf);
    wide_t lim;
    lim = (wide_t'(1) <<< (bits - 1)) - 1;
    if (v > lim) begin
      v = lim;
      ovf = 1'b1;
    end
    if (v < -lim - 1) begin
      v = -lim - 1;
      ovf = 1'b1;
    end
    return v[63:0];
  endfunction

  // Expected circle for one point triple.
  function automatic ctp_pkg::ctp_out_t predict_circle(ctp_pkg::ctp_in_t p);
    ctp_pkg::ctp_out_t res;
    wide_t    x1, y1, u2, v2, u3, v3, det, s2, s3, qx, qy, cnum, rad, lim;
    bit       ovf;
    res = '0;
    ovf = 1'b0;
    x1 = p.first_x;
    y1 = p.first_y;
    u2 = wide_t'(p.second_x) - x1;
    v2 = wide_t'(p.second_y) - y1;
    u3 = wide_t'(p.third_x) - x1;
    v3 = wide_t'(p.third_y) - y1;
    det = u2 * v3 - u3 * v2;
    if (det == 0) begin
      res.collinear = 1'b1;
      return res;
    end
    det = 2 * det;
    s2 = u2 * u2 + v2 * v2;
    s3 = u3 * u3 + v3 * v3;
    qx = div_nearest(v3 * s2 - v2 * s3, det);
    qy = div_nearest(u2 * s3 - u3 * s2, det);
    res.half_x_coefficient = 48'(clamp_signed(-(x1 + qx), 48, ovf));
    res.half_y_coefficient = 48'(clamp_signed(-(y1 + qy), 48, ovf));
    cnum = x1 * x1 + y1 * y1 + 2 * x1 * qx + 2 * y1 * qy;
    res.constant_term = clamp_signed(
        div_nearest(cnum, wide_t'(1) << ctp_pkg::FRACTION_BITS_DEF), 64, ovf);
    rad = sqrt_nearest(qx * qx + qy * qy);
    lim = (wide_t'(1) << 48) - 1;
    if (rad > lim) begin
      rad = lim;
      ovf = 1'b1;
    end
    res.radius   = rad[47:0];
    res.overflow = ovf;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, field, got, want);
    error_count++;
  endtask

  // Result checker: each strobed word against the oldest expectation.
  always @(posedge clk) begin
    ctp_pkg::ctp_out_t want;
    if (rst_n && out_valid) begin
      if (circle_q.size() == 0) begin
        $display("%0t: result word with nothing expected", $realtime);
        error_count++;
      end else begin
        want = circle_q.pop_front();
        if (out_res.half_x_coefficient !== want.half_x_coefficient)
          report_mismatch("half_x_coefficient", 64'(out_res.half_x_coefficient),
                          64'(want.half_x_coefficient));
        if (out_res.half_y_coefficient !== want.half_y_coefficient)
          report_mismatch("half_y_coefficient", 64'(out_res.half_y_coefficient),
                          64'(want.half_y_coefficient));
        if (out_res.constant_term !== want.constant_term)
          report_mismatch("constant_term", out_res.constant_term, want.constant_term);
        if (out_res.radius !== want.radius)
          report_mismatch("radius", 64'(out_res.radius), 64'(want.radius));
        if (out_res.collinear !== want.collinear)
          report_mismatch("collinear", 64'(out_res.collinear), 64'(want.collinear));
        if (out_res.overflow !== want.overflow)
          report_mismatch("overflow", 64'(out_res.overflow), 64'(want.overflow));
      end
    end
  end

  // Send one word: hold start until accepted, then record the expectation.
  // Between bursts the sender may drop start for a random gap.
  task automatic send_points(ctp_pkg::ctp_in_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start  <= 1'b1;
    in_pts <= p;
    do @(posedge clk); while (busy);
    circle_q.push_back(predict_circle(p));
  endtask

  function automatic ctp_pkg::ctp_in_t make_points(int x1, int y1, int x2, int y2,
                                                   int x3, int y3);
    ctp_pkg::ctp_in_t p;
    p.first_x  = x1;
    p.first_y  = y1;
    p.second_x = x2;
    p.second_y = y2;
    p.third_x  = x3;
    p.third_y  = y3;
    return p;
  endfunction

  // Exactly collinear triple with small direction and multipliers.
  function automatic ctp_pkg::ctp_in_t make_collinear();
    int x1, y1, dx, dy, k2, k3;
    x1 = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
    y1 = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
    dx = $signed($urandom_range(0, 2048)) - 1024;
    dy = $signed($urandom_range(0, 2048)) - 1024;
    k2 = $signed($urandom_range(0, 200)) - 100;
    k3 = $signed($urandom_range(0, 200)) - 100;
    return make_points(x1, y1, x1 + k2 * dx, y1 + k2 * dy, x1 + k3 * dx, y1 + k3 * dy);
  endfunction

  task automatic test_directed_shapes();
    int one;
    one = 1 << ctp_pkg::FRACTION_BITS_DEF;
    // Unit right triangle, a plain circle.
    send_points(make_points(0, 0, one, 0, 0, one));
    send_points(make_points(-one, 0, one, 0, 0, one));
    send_points(make_points(3 * one, 4 * one, -5 * one, 0, 0, -5 * one));
    // Smallest nonzero triangle.
    send_points(make_points(0, 0, 1, 0, 0, 1));
    // Equal y on the first two points.
    send_points(make_points(one, 2 * one, -one, 2 * one, 7, -9 * one));
    // Extremes of the coordinate range.
    send_points(make_points(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                            32'h80000000, 32'h80000000));
    send_points(make_points(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                            32'h7fffffff, 32'h7fffffff));
    send_points(make_points(32'h7fffffff, 0, 32'h80000000, 0, 0, 32'h7fffffff));
    send_points(make_points(-1, -1, 32'h7fffffff, -1, -1, 32'h80000000));
    // Coincident points and collinear points.
    send_points(make_points(one, one, one, one, one, one));
    send_points(make_points(one, one, one, one, 5 * one, -3 * one));
    send_points(make_points(0, 0, one, one, 2 * one, 2 * one));
    send_points(make_points(32'h80000000, 0, 0, 0, 32'h7fffffff, 0));
    // Nearly collinear points, centre far away.
    send_points(make_points(32'h80000000, 0, 32'h7fffffff, 0, 0, 1));
    send_points(make_points(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7ffffffe,
                            0, 0));
    send_points(make_points(0, 0, 1, 1, 32'h7fffffff, 32'h7ffffffe));
  endtask

  task automatic test_random_wide(int count);
    repeat (count)
      send_points(make_points($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic test_random_compact(int count);
    int span;
    repeat (count) begin
      span = 2 ** $urandom_range(2, 24);
      send_points(make_points($signed($urandom_range(0, 2 * span)) - span,
                              $signed($urandom_range(0, 2 * span)) - span,
                              $signed($urandom_range(0, 2 * span)) - span,
                              $signed($urandom_range(0, 2 * span)) - span,
                              $signed($urandom_range(0, 2 * span)) - span,
                              $signed($urandom_range(0, 2 * span)) - span));
    end
  endtask

  // Collinear triples, some nudged by one step to give huge circles.
  task automatic test_degenerate(int count);
    ctp_pkg::ctp_in_t p;
    repeat (count) begin
      p = make_collinear();
      case ($urandom_range(0, 2))
        0: p.third_x = p.third_x + 1;
        1: p.third_y = p.third_y - 1;
        default: ;
      endcase
      send_points(p);
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_pts      = '0;
    error_count = 0;
    burst_left  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_shapes();
    test_random_wide(500);
    test_random_compact(500);
    test_degenerate(300);

    start <= 1'b0;
    while (circle_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("circle_through_three_points_tb: done, clean");
    end else begin
      $display("circle_through_three_points_tb: done, errors");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #2000000;
    $display("circle_through_three_points_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
